@@ hdl/lkv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and codes
// Item formats, operation and status codes and sequencer states of the
// linear key/value table.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;

   // operation kinds
   localparam logic [2:0] KIND_GET    = 3'd0;
   localparam logic [2:0] KIND_PUT    = 3'd1;
   localparam logic [2:0] KIND_DELETE = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_LIST   = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_REPLACED  = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   key_out;
      logic [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_LIST,
      ST_RESP
   } seq_state_type;

endpackage

@@ hdl/linear_key_value_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_key_value_table: insertion-ordered key/value table
// Usage:
//   req_*  input items (kind, key, value); accepted when req_valid is high
//          and req_stall is low. req_stall is high while an item is in work.
//   rsp_*  result items from an output register; taken when rsp_valid is
//          high and rsp_stall is low. List gives one item per stored pair (one
//          if none), every other kind exactly one; last marks the final one.
// Operation:
//   get/put   one shared key comparator checks one entry per cycle from memory.
//   delete    search plus shift-down, one entry per cycle through the single
//             memory port pair.
//   clear     empties the table. list: the first pair, then one per cycle
//             while the receiver does not stall.
//   The next item is accepted in the cycle after the last result leaves the
//   sequencer.
// Reset clears the pair count and all valid flags; memory contents are left
//   as they are, entries beyond the count are never read.
// A stalled receiver holds the output register; the sequencer waits in
//   place until the register frees, without losing or repeating items.
// ----------------------------------------------------------------------------
module linear_key_value_table
   import lkv_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // stored key width: keys are masked to KEY_BITS, and never wider than the field
   localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int MW = KW + VALUE_W;
   localparam int IW = $clog2(CAPACITY);

   logic          req_ready;
   logic          res_valid;
   logic          res_ready;
   rsp_type       res_data;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic [MW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   logic [MW-1:0] mem_rd_data;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   lkv_seq #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // key and value of each pair side by side in one word
   lkv_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall = !req_ready;

   // register is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/lkv_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_mem: pair storage
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module lkv_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lkv_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_seq: table sequencer
// Walks the pair memory one entry a cycle via one key comparator: search,
// in-place update, append, shift-down on delete, listing as results are taken.
// ----------------------------------------------------------------------------
module lkv_seq
   import lkv_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_ready,
   input  req_type                                               req_data,
   output logic                                                  res_valid,
   input  logic                                                  res_ready,
   output rsp_type                                               res_data,
   output logic                                                  mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]                           mem_wr_addr,
   output logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)+VALUE_W-1:0] mem_wr_data,
   output logic                                                  mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]                           mem_rd_addr,
   input  logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)+VALUE_W-1:0] mem_rd_data
);

   localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   function automatic logic [KEY_W-1:0] key_ext(input logic [KW-1:0] k);
      logic [KW+KEY_W-1:0] w;
      w = {{KEY_W{1'b0}}, k};
      return w[KEY_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] cnt_ext(input logic [CW-1:0] c);
      logic [CW+COUNT_W-1:0] w;
      w = {{COUNT_W{1'b0}}, c};
      return w[COUNT_W-1:0];
   endfunction

   seq_state_type state_ff, state_in;
   req_type       item_ff, item_in;
   rsp_type       res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic [KW-1:0]      item_key;
   logic [KW-1:0]      req_key;
   logic [KW-1:0]      q_key;
   logic [VALUE_W-1:0] q_val;
   logic               hit;
   logic               list_last;

   assign item_key  = item_ff.key[KW-1:0];
   assign req_key   = req_data.key[KW-1:0];
   assign q_key     = mem_rd_data[KW+VALUE_W-1:VALUE_W];
   assign q_val     = mem_rd_data[VALUE_W-1:0];
   assign hit       = rd_vld_ff && (q_key == item_key);
   assign list_last = (rd_ptr_ff + CW'(1)) == cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      res_ff    <= res_in;
      rd_ptr_ff <= rd_ptr_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      res_in      = res_ff;
      cnt_in      = cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_vld_in   = rd_vld_ff;
      rd_idx_in   = rd_idx_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res_data    = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = rd_idx_ff;
      mem_wr_data = {item_key, item_ff.value};
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_ptr_ff[IW-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_vld_in = 1'b0;
            if (req_valid) begin
               item_in           = req_data;
               rd_ptr_in         = '0;
               res_in.key_out    = key_ext(req_key);
               res_in.value_out  = '0;
               res_in.count      = cnt_ext(cnt_ff);
               res_in.last       = 1'b1;
               res_in.status     = STATUS_NOT_FOUND;
               case (req_data.kind)
                  KIND_GET, KIND_PUT, KIND_DELETE: begin
                     state_in = ST_SCAN;
                  end
                  KIND_CLEAR: begin
                     res_in.status = STATUS_OK;
                     cnt_in        = '0;
                     state_in      = ST_RESP;
                  end
                  KIND_LIST: begin
                     if (cnt_ff == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_in    = ST_LIST;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rd_vld_in = 1'b0;
            if (hit) begin
               case (item_ff.kind)
                  KIND_GET: begin
                     res_in.status    = STATUS_OK;
                     res_in.value_out = q_val;
                     state_in         = ST_RESP;
                  end
                  KIND_PUT: begin
                     mem_wr_en        = 1'b1;
                     mem_wr_addr      = rd_idx_ff;
                     res_in.status    = STATUS_REPLACED;
                     res_in.value_out = item_ff.value;
                     state_in         = ST_RESP;
                  end
                  default: begin
                     // delete: keep removed value, then close the gap
                     res_in.status    = STATUS_OK;
                     res_in.value_out = q_val;
                     rd_ptr_in        = CW'(rd_idx_ff) + CW'(1);
                     state_in         = ST_SHIFT;
                  end
               endcase
            end else if (rd_ptr_ff == cnt_ff) begin
               state_in = ST_RESP;
               if (item_ff.kind == KIND_PUT) begin
                  if (cnt_ff == CW'(CAPACITY)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     mem_wr_en        = 1'b1;
                     mem_wr_addr      = cnt_ff[IW-1:0];
                     cnt_in           = cnt_ff + CW'(1);
                     res_in.status    = STATUS_OK;
                     res_in.value_out = item_ff.value;
                     res_in.count     = cnt_ext(cnt_ff + CW'(1));
                  end
               end
            end else begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = rd_ptr_ff[IW-1:0];
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
         end

         ST_SHIFT: begin
            rd_vld_in = 1'b0;
            if (rd_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = rd_idx_ff - IW'(1);
               mem_wr_data = mem_rd_data;
            end
            if (rd_ptr_ff != cnt_ff) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = rd_ptr_ff[IW-1:0];
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end else begin
               cnt_in       = cnt_ff - CW'(1);
               res_in.count = cnt_ext(cnt_ff - CW'(1));
               state_in     = ST_RESP;
            end
         end

         ST_LIST: begin
            res_valid          = 1'b1;
            res_data.status    = STATUS_OK;
            res_data.key_out   = key_ext(q_key);
            res_data.value_out = q_val;
            res_data.count     = cnt_ext(cnt_ff);
            res_data.last      = list_last;
            if (res_ready) begin
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in   = rd_ptr_ff + CW'(1);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rd_ptr_in[IW-1:0];
               end
            end
         end

         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
